[design/rti_pkg.sv]
// shared constants for the ray / triangle intersection block
package rti_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // parallel threshold and distance code widths
   localparam int THR_W  = 32;
   localparam int DIST_W = 31;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_ORIGIN_Z  = 3'd2,
      REG_DIR_X     = 3'd3,
      REG_DIR_Y     = 3'd4,
      REG_DIR_Z     = 3'd5,
      REG_THRESHOLD = 3'd6
   } csr_index_type;

   // partial product slice width of the wide multipliers
   localparam int MUL_SLICE = 32;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

endpackage

[design/rti_if.sv]
// request and response channel interfaces
interface rti_req_if #(parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
   logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
   logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   input ready);
   modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 output ready);
endinterface

interface rti_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [rti_pkg::DIST_W-1:0] hit_distance;

   modport source (output valid, hit, hit_distance, input ready);
   modport sink (input valid, hit, hit_distance, output ready);
endinterface

[design/rti_mul.sv]
// two stage signed multiplier built from sliced partial products
module rti_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [AW-1:0]      a,
   input  logic signed [BW-1:0]      b,
   output logic signed [AW+BW-1:0]   p
);
   import rti_pkg::*;

   localparam int NS = (AW + MUL_SLICE - 1) / MUL_SLICE;
   localparam int EW = NS * MUL_SLICE;
   localparam int PPW = MUL_SLICE + BW + 1;
   localparam int OW = AW + BW;

   logic signed [EW-1:0]  a_ext;
   logic signed [PPW-1:0] pp_in [NS];
   logic signed [PPW-1:0] pp_ff [NS];
   logic signed [OW-1:0]  acc;

   assign a_ext = EW'(a);

   // partial products, low slices unsigned, top slice signed
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == NS - 1) begin
            pp_in[k] = PPW'($signed(a_ext[k*MUL_SLICE +: MUL_SLICE]) * b);
         end else begin
            pp_in[k] = PPW'($signed({1'b0, a_ext[k*MUL_SLICE +: MUL_SLICE]}) * b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
      end
   end

   // weighted sum of the slices
   always_comb begin
      acc = '0;
      for (int k = 0; k < NS; k++) begin
         acc = acc + (OW'(pp_ff[k]) <<< (k * MUL_SLICE));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p <= acc;
      end
   end

endmodule

[design/rti_queue.sv]
// small fifo between the front and back parts
module rti_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output logic [WIDTH-1:0] dout
);
   import rti_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign dout     = mem[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= din;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !nonempty))
      else $error("pop from empty queue");

endmodule

[design/rti_front.sv]
// front part: edges, normal, dot products and hit classification
module rti_front #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rti_req_if.sink                               req_bus,
   input  logic signed [COORD_WIDTH-1:0]         org_x, org_y, org_z,
   input  logic signed [COORD_WIDTH-1:0]         dir_x, dir_y, dir_z,
   input  logic [rti_pkg::THR_W-1:0]             threshold,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic                                  q_hit,
   output logic [3*COORD_WIDTH+4:0]              q_det,
   output logic [3*COORD_WIDTH+4:0]              q_tn
);
   import rti_pkg::*;

   localparam int C  = COORD_WIDTH;
   localparam int D1 = C + 1;
   localparam int NW = 2 * C + 3;
   localparam int WW = 2 * C + 2;
   localparam int PW = 3 * C + 6;

   logic [8:1] vld_ff;
   logic       fe;

   logic signed [C-1:0]    p0 [3], p1 [3], p2 [3], org [3], dir [3];
   logic signed [D1-1:0]   e0_in [3], e1_in [3], a_in [3];
   logic signed [D1-1:0]   e0_1_ff [3], e1_1_ff [3], a_1_ff [3];
   logic signed [D1-1:0]   e0_2_ff [3], e1_2_ff [3], a_2_ff [3];
   logic signed [D1-1:0]   e0_3_ff [3], e1_3_ff [3], a_3_ff [3];
   logic signed [2*D1-1:0] np_ff [6];
   logic signed [C+D1-1:0] wp_ff [6];
   logic signed [NW-1:0]   n_ff [3];
   logic signed [WW-1:0]   w_ff [3];
   logic signed [NW+C-1:0] dt_p [3];
   logic signed [NW+D1-1:0] tn_p [3];
   logic signed [WW+D1-1:0] un_p [3], vn_p [3];
   logic signed [PW-1:0]   det_ff, tn_ff, un_ff, vn_ff;
   logic signed [PW-1:0]   det7_ff, tn7_ff, un7_ff, vn7_ff;
   logic signed [PW:0]     uv_sum;
   logic                   hit_in, hit_ff;
   logic [PW-2:0]          det8_ff, tn8_ff;

   // stall the whole front when its last stage cannot enter the queue
   assign fe            = !(vld_ff[8] && q_full);
   assign req_bus.ready = fe;
   assign q_push        = vld_ff[8] && fe;
   assign q_hit         = hit_ff;
   assign q_det         = det8_ff;
   assign q_tn          = tn8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (fe) begin
         vld_ff <= {vld_ff[7:1], req_bus.valid};
      end
   end

   // vertex and ray vectors
   always_comb begin
      p0[0] = req_bus.v0_x; p0[1] = req_bus.v0_y; p0[2] = req_bus.v0_z;
      p1[0] = req_bus.v1_x; p1[1] = req_bus.v1_y; p1[2] = req_bus.v1_z;
      p2[0] = req_bus.v2_x; p2[1] = req_bus.v2_y; p2[2] = req_bus.v2_z;
      org[0] = org_x; org[1] = org_y; org[2] = org_z;
      dir[0] = dir_x; dir[1] = dir_y; dir[2] = dir_z;
      for (int i = 0; i < 3; i++) begin
         e0_in[i] = D1'(p1[i]) - D1'(p0[i]);
         e1_in[i] = D1'(p0[i]) - D1'(p2[i]);
         a_in[i]  = D1'(p0[i]) - D1'(org[i]);
      end
   end

   // stage 1 edges, stage 2 cross products, stage 3 normal and w
   always_ff @(posedge clock) begin
      if (fe) begin
         e0_1_ff <= e0_in;
         e1_1_ff <= e1_in;
         a_1_ff  <= a_in;

         np_ff[0] <= e1_1_ff[1] * e0_1_ff[2];
         np_ff[1] <= e1_1_ff[2] * e0_1_ff[1];
         np_ff[2] <= e1_1_ff[2] * e0_1_ff[0];
         np_ff[3] <= e1_1_ff[0] * e0_1_ff[2];
         np_ff[4] <= e1_1_ff[0] * e0_1_ff[1];
         np_ff[5] <= e1_1_ff[1] * e0_1_ff[0];
         wp_ff[0] <= dir[1] * a_1_ff[2];
         wp_ff[1] <= dir[2] * a_1_ff[1];
         wp_ff[2] <= dir[2] * a_1_ff[0];
         wp_ff[3] <= dir[0] * a_1_ff[2];
         wp_ff[4] <= dir[0] * a_1_ff[1];
         wp_ff[5] <= dir[1] * a_1_ff[0];
         e0_2_ff <= e0_1_ff;
         e1_2_ff <= e1_1_ff;
         a_2_ff  <= a_1_ff;

         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= NW'(np_ff[2*i]) - NW'(np_ff[2*i+1]);
            w_ff[i] <= WW'(wp_ff[2*i]) - WW'(wp_ff[2*i+1]);
         end
         e0_3_ff <= e0_2_ff;
         e1_3_ff <= e1_2_ff;
         a_3_ff  <= a_2_ff;
      end
   end

   // stages 4 and 5: the dot product terms
   for (genvar i = 0; i < 3; i++) begin : g_dot
      rti_mul #(.AW(NW), .BW(C)) u_det_mul (
         .clock(clock), .en(fe), .a(n_ff[i]), .b(dir[i]), .p(dt_p[i]));
      rti_mul #(.AW(NW), .BW(D1)) u_tn_mul (
         .clock(clock), .en(fe), .a(n_ff[i]), .b(a_3_ff[i]), .p(tn_p[i]));
      rti_mul #(.AW(WW), .BW(D1)) u_un_mul (
         .clock(clock), .en(fe), .a(w_ff[i]), .b(e1_3_ff[i]), .p(un_p[i]));
      rti_mul #(.AW(WW), .BW(D1)) u_vn_mul (
         .clock(clock), .en(fe), .a(w_ff[i]), .b(e0_3_ff[i]), .p(vn_p[i]));
   end

   // stage 6 sums, stage 7 sign fold, stage 8 classification
   assign uv_sum = (PW+1)'(un7_ff) + (PW+1)'(vn7_ff);
   assign hit_in = (det7_ff != '0)
                && (det7_ff >= PW'($signed({1'b0, threshold})))
                && !tn7_ff[PW-1] && !un7_ff[PW-1] && !vn7_ff[PW-1]
                && (uv_sum <= (PW+1)'(det7_ff));

   always_ff @(posedge clock) begin
      if (fe) begin
         det_ff <= PW'(dt_p[0]) + PW'(dt_p[1]) + PW'(dt_p[2]);
         tn_ff  <= PW'(tn_p[0]) + PW'(tn_p[1]) + PW'(tn_p[2]);
         un_ff  <= PW'(un_p[0]) + PW'(un_p[1]) + PW'(un_p[2]);
         vn_ff  <= PW'(vn_p[0]) + PW'(vn_p[1]) + PW'(vn_p[2]);

         if (det_ff[PW-1]) begin
            det7_ff <= -det_ff;
            tn7_ff  <= -tn_ff;
            un7_ff  <= -un_ff;
            vn7_ff  <= -vn_ff;
         end else begin
            det7_ff <= det_ff;
            tn7_ff  <= tn_ff;
            un7_ff  <= un_ff;
            vn7_ff  <= vn_ff;
         end

         hit_ff  <= hit_in;
         det8_ff <= det7_ff[PW-2:0];
         tn8_ff  <= tn7_ff[PW-2:0];
      end
   end

endmodule

[design/rti_back.sv]
// back part: pipelined restoring division for the hit distance
module rti_back #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  logic                      q_hit,
   input  logic [3*COORD_WIDTH+4:0]  q_det,
   input  logic [3*COORD_WIDTH+4:0]  q_tn,
   output logic                      q_pop,
   rti_rsp_if.source                 rsp_bus
);
   import rti_pkg::*;

   localparam int MW = 3 * COORD_WIDTH + 5;
   localparam int RW = MW + FRAC_BITS + DIST_W + 1;
   localparam int NS = DIST_W + 1;

   logic [NS:0]        bv_ff;
   logic               be;
   logic [RW-1:0]      num0, lim0;
   logic [RW-1:0]      r_ff   [NS];
   logic [MW-1:0]      det_ff [NS];
   logic [DIST_W-1:0]  q_ff   [NS];
   logic               hit_ff [NS];
   logic               sat_ff [NS];
   logic               out_hit_ff;
   logic [DIST_W-1:0]  out_dist_ff;

   // the back advances unless the output register is held
   assign be    = !bv_ff[NS] || rsp_bus.ready;
   assign q_pop = be && q_valid;

   assign rsp_bus.valid        = bv_ff[NS];
   assign rsp_bus.hit          = out_hit_ff;
   assign rsp_bus.hit_distance = out_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else if (be) begin
         bv_ff <= {bv_ff[NS-1:0], q_valid};
      end
   end

   // stage 0: scaled numerator and saturation check
   assign num0 = RW'(q_tn) << FRAC_BITS;
   assign lim0 = RW'(q_det) << DIST_W;

   always_ff @(posedge clock) begin
      if (be) begin
         r_ff[0]   <= num0;
         det_ff[0] <= q_det;
         q_ff[0]   <= '0;
         hit_ff[0] <= q_hit;
         sat_ff[0] <= (num0 >= lim0);
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 1; j < NS; j++) begin : g_div
      localparam int B = DIST_W - j;
      logic [RW-1:0] dsh;
      logic          ge;

      assign dsh = RW'(det_ff[j-1]) << B;
      assign ge  = (r_ff[j-1] >= dsh);

      always_ff @(posedge clock) begin
         if (be) begin
            r_ff[j]   <= ge ? (r_ff[j-1] - dsh) : r_ff[j-1];
            q_ff[j]   <= q_ff[j-1] | (DIST_W'(ge) << B);
            det_ff[j] <= det_ff[j-1];
            hit_ff[j] <= hit_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (be) begin
         out_hit_ff  <= hit_ff[NS-1];
         out_dist_ff <= (hit_ff[NS-1] && !sat_ff[NS-1]) ? q_ff[NS-1] : DIST_MAX;
      end
   end

endmodule

[design/ray_triangle_intersection_top.sv]
// top level of the ray / triangle intersection block
// Tests one triangle per transaction against a ray held in the csr registers and returns one
// response per request: hit and the hit distance in unsigned Q15.16 (maximum code on a miss or
// when the distance overflows). The block takes one request per clock cycle while the queue is
// not full. A request passes through eight front stages (edges, cross products, sliced
// dot-product multipliers, sign fold, classification), the queue, and a 32-stage back pipeline
// (an overflow check, then one quotient bit per stage) ahead of the output register.
// A four-entry queue lets the front keep accepting while the response side stalls. Write the
// csr registers only while no request is in flight.
module ray_triangle_intersection_top #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   rti_req_if.sink                                           req_bus,
   rti_rsp_if.source                                         rsp_bus,
   input  logic                                              csr_we,
   input  logic [rti_pkg::CSR_INDEX_W-1:0]                   csr_index,
   input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_wdata
);
   import rti_pkg::*;

   localparam int MW = 3 * COORD_WIDTH + 5;
   localparam int QW = 1 + 2 * MW;

   logic signed [COORD_WIDTH-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [COORD_WIDTH-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [THR_W-1:0]              thr_ff;
   logic                          q_full, q_push, q_hit, q_pop, q_valid;
   logic [MW-1:0]                 q_det, q_tn;
   logic [QW-1:0]                 q_dout;
   logic signed [COORD_WIDTH-1:0] wval;

   assign wval = csr_wdata[COORD_WIDTH-1:0];

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         dir_x_ff <= COORD_WIDTH'(1) << FRAC_BITS;
         dir_y_ff <= '0;
         dir_z_ff <= '0;
         thr_ff   <= THR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X:  org_x_ff <= wval;
            REG_ORIGIN_Y:  org_y_ff <= wval;
            REG_ORIGIN_Z:  org_z_ff <= wval;
            REG_DIR_X:     dir_x_ff <= wval;
            REG_DIR_Y:     dir_y_ff <= wval;
            REG_DIR_Z:     dir_z_ff <= wval;
            REG_THRESHOLD: thr_ff   <= csr_wdata[THR_W-1:0];
            default:       ;
         endcase
      end
   end

   rti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus),
      .org_x(org_x_ff), .org_y(org_y_ff), .org_z(org_z_ff),
      .dir_x(dir_x_ff), .dir_y(dir_y_ff), .dir_z(dir_z_ff),
      .threshold(thr_ff), .q_full(q_full),
      .q_push(q_push), .q_hit(q_hit), .q_det(q_det), .q_tn(q_tn));

   rti_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .din({q_hit, q_det, q_tn}), .full(q_full),
      .pop(q_pop), .nonempty(q_valid), .dout(q_dout));

   rti_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid),
      .q_hit(q_dout[QW-1]), .q_det(q_dout[2*MW-1:MW]), .q_tn(q_dout[MW-1:0]),
      .q_pop(q_pop), .rsp_bus(rsp_bus));

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |-> rsp_bus.hit_distance == DIST_MAX)
      else $error("miss without maximum distance code");
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_bus.valid)
      else $error("response valid right after reset");
   assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == REG_THRESHOLD |=> thr_ff == $past(csr_wdata[THR_W-1:0]))
      else $error("threshold write lost");

endmodule
